@@ sv/utf8d_pkg.sv @@
// utf8d_pkg: shared types and constants of the utf-8 stream decoder
// used by every module of the decoder; depends on nothing
`default_nettype none

package utf8d_pkg;

    localparam int BYTE_W      = 8;
    localparam int CP_W        = 21;
    localparam int PEND_W      = 2;
    localparam int QUEUE_DEPTH = 4;

    // byte classes, as mask and tag pairs
    localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] ASCII_TAG  = 8'h00;
    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG   = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
    localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
    localparam logic [BYTE_W-1:0] LEAD4_TAG  = 8'hF0;

    // payload bits carried by each byte kind
    localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;
    localparam int                CONT_BITS  = 6;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            malformed;
        logic            is_last;
    } result_t;

    // one queue entry: the results of one accepted byte
    typedef struct packed {
        logic    two;
        result_t res0;
        result_t res1;
    } job_t;

endpackage

`default_nettype wire

@@ sv/utf8d_front.sv @@
// utf8d_front: accepts bytes, keeps the open sequence and forms the results of each byte
// depends on utf8d_pkg
`default_nettype none

module utf8d_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire logic [utf8d_pkg::BYTE_W-1:0]    byte_in,
    output utf8d_pkg::job_t                      job,
    output logic                                 job_valid
);

    logic [utf8d_pkg::PEND_W-1:0] pend_reg, pend_next;
    logic [utf8d_pkg::CP_W-1:0]   part_reg, part_next;

    utf8d_pkg::result_t           lead_res;
    logic                         lead_has;
    logic [utf8d_pkg::PEND_W-1:0] lead_pend;
    logic [utf8d_pkg::CP_W-1:0]   lead_part;
    logic [utf8d_pkg::CP_W-1:0]   cont_part;
    logic [utf8d_pkg::PEND_W-1:0] cont_pend;
    logic                         is_cont;

    // decode the byte as if no sequence were open
    always_comb
    begin
        lead_res  = '{code_point: '0, malformed: 1'b1, is_last: 1'b1};
        lead_has  = 1'b1;
        lead_pend = '0;
        lead_part = '0;
        priority if ((byte_in & utf8d_pkg::ASCII_MASK) == utf8d_pkg::ASCII_TAG)
        begin
            lead_res.code_point = utf8d_pkg::CP_W'(byte_in);
            lead_res.malformed  = 1'b0;
        end
        else if ((byte_in & utf8d_pkg::LEAD2_MASK) == utf8d_pkg::LEAD2_TAG)
        begin
            lead_has  = 1'b0;
            lead_pend = 2'd1;
            lead_part = utf8d_pkg::CP_W'(byte_in & utf8d_pkg::LEAD2_BITS);
        end
        else if ((byte_in & utf8d_pkg::LEAD3_MASK) == utf8d_pkg::LEAD3_TAG)
        begin
            lead_has  = 1'b0;
            lead_pend = 2'd2;
            lead_part = utf8d_pkg::CP_W'(byte_in & utf8d_pkg::LEAD3_BITS);
        end
        else if ((byte_in & utf8d_pkg::LEAD4_MASK) == utf8d_pkg::LEAD4_TAG)
        begin
            lead_has  = 1'b0;
            lead_pend = 2'd3;
            lead_part = utf8d_pkg::CP_W'(byte_in & utf8d_pkg::LEAD4_BITS);
        end
        else
        begin
            // stray continuation or invalid lead: malformed result stays as set
            lead_has = 1'b1;
        end
    end

    assign is_cont   = (byte_in & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_TAG;
    assign cont_part = {part_reg[utf8d_pkg::CP_W-utf8d_pkg::CONT_BITS-1:0],
                        byte_in[utf8d_pkg::CONT_BITS-1:0]};
    assign cont_pend = pend_reg - 2'd1;

    always_comb
    begin
        job       = '0;
        job_valid = 1'b0;
        pend_next = pend_reg;
        part_next = part_reg;
        priority if (pend_reg == '0)
        begin
            job.res0  = lead_res;
            job_valid = lead_has;
            pend_next = lead_pend;
            part_next = lead_part;
        end
        else if (is_cont)
        begin
            pend_next = cont_pend;
            if (cont_pend == '0)
            begin
                job.res0  = '{code_point: cont_part, malformed: 1'b0, is_last: 1'b1};
                job_valid = 1'b1;
                part_next = '0;
            end
            else
            begin
                part_next = cont_part;
            end
        end
        else
        begin
            // interrupted sequence: report it, then treat the byte as a lead
            job.res0  = '{code_point: '0, malformed: 1'b1, is_last: !lead_has};
            job.two   = lead_has;
            job.res1  = lead_res;
            job_valid = 1'b1;
            pend_next = lead_pend;
            part_next = lead_part;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            part_reg <= '0;
        end
        else if (accept)
        begin
            pend_reg <= pend_next;
            part_reg <= part_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/utf8d_queue.sv @@
// utf8d_queue: short first-in first-out queue of jobs between front and back
// depends on utf8d_pkg
`default_nettype none

module utf8d_queue #(
    parameter int DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            wr_en,
    input  wire utf8d_pkg::job_t wr_data,
    output logic                 full,
    input  wire logic            rd_en,
    output utf8d_pkg::job_t      rd_data,
    output logic                 empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    utf8d_pkg::job_t mem [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full    = count_reg == CW'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/utf8d_back.sv @@
// utf8d_back: takes jobs from the queue and hands out their results one per transaction
// depends on utf8d_pkg
`default_nettype none

module utf8d_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire utf8d_pkg::job_t               head,
    input  wire logic                          q_empty,
    output logic                               q_rd,
    input  wire logic                          pop,
    output logic                               empty,
    output logic [utf8d_pkg::CP_W-1:0]         code_point,
    output logic                               malformed,
    output logic                               is_last
);

    logic               out_valid_reg;
    utf8d_pkg::result_t out_reg;
    logic               second_valid_reg;
    utf8d_pkg::result_t second_reg;
    logic               load;
    logic               take_second;

    // the output register may refill whenever it is free or being taken
    assign load        = !out_valid_reg || pop;
    assign take_second = load && second_valid_reg;
    assign q_rd        = load && !second_valid_reg && !q_empty;

    assign empty      = !out_valid_reg;
    assign code_point = out_reg.code_point;
    assign malformed  = out_reg.malformed;
    assign is_last    = out_reg.is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            second_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= second_valid_reg || !q_empty;
            if (take_second)
            begin
                second_valid_reg <= 1'b0;
            end
            else if (q_rd)
            begin
                second_valid_reg <= head.two;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_second)
        begin
            out_reg <= second_reg;
        end
        else if (q_rd)
        begin
            out_reg    <= head.res0;
            second_reg <= head.res1;
        end
    end

endmodule

`default_nettype wire

@@ sv/utf8_stream_decoder.sv @@
// utf8_stream_decoder: utf-8 byte stream to code point decoder, top level
// depends on utf8d_pkg, utf8d_front, utf8d_queue, utf8d_back
//
// usage:
//   input channel: one raw byte per transaction; a byte is taken at a rising
//   edge with push high and full low
//   result channel: code_point, malformed and is_last of the oldest result are
//   valid while empty is low; the result is taken at an edge with pop high
//   a lead byte that opens a sequence gives no result; a finished sequence or an
//   ascii byte gives one; an interrupted sequence gives a malformed result and,
//   if the new byte completes on its own, a second one; is_last marks the final
//   result of each byte
//   throughput: one byte per cycle while full is low; a byte with two results
//   holds the result port until both of them are popped
//   path: a job is queued at the accepting edge; the output register loads it
//   from the queue at an edge where the register is free or its result is popped
//   reset: sequence state, queue and output valid flags clear; empty goes high
//   stalls: while pop is low the result holds, the job queue fills, and full
//   rises once QUEUE_DEPTH jobs wait
`default_nettype none

module utf8_stream_decoder #(
    parameter int QUEUE_DEPTH = utf8d_pkg::QUEUE_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [utf8d_pkg::BYTE_W-1:0]  byte_in,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [utf8d_pkg::CP_W-1:0]         code_point,
    output logic                               malformed,
    output logic                               is_last
);

    utf8d_pkg::job_t job;
    utf8d_pkg::job_t head;
    logic            job_valid;
    logic            accept;
    logic            q_empty;
    logic            q_rd;

    assign accept = push && !full;

    utf8d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .byte_in   (byte_in),
        .job       (job),
        .job_valid (job_valid)
    );

    utf8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && job_valid),
        .wr_data (job),
        .full    (full),
        .rd_en   (q_rd),
        .rd_data (head),
        .empty   (q_empty)
    );

    utf8d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_empty    (q_empty),
        .q_rd       (q_rd),
        .pop        (pop),
        .empty      (empty),
        .code_point (code_point),
        .malformed  (malformed),
        .is_last    (is_last)
    );

endmodule

`default_nettype wire

@@ sv/utf8d_checker.sv @@
// utf8d_checker: port-level checks of the utf-8 stream decoder, bound to the top level
// depends on utf8d_pkg and utf8_stream_decoder
`default_nettype none

module utf8d_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire logic                          full,
    input  wire logic [utf8d_pkg::BYTE_W-1:0]  byte_in,
    input  wire logic                          empty,
    input  wire logic                          pop,
    input  wire logic [utf8d_pkg::CP_W-1:0]    code_point,
    input  wire logic                          malformed,
    input  wire logic                          is_last
);

    // a waiting result holds until its transaction completes
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(code_point) && $stable(malformed)
                              && $stable(is_last)))
        else $error("result changed while stalled");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && malformed) |-> (code_point == '0))
        else $error("malformed result with nonzero code point");

    a_good_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !malformed) |-> is_last)
        else $error("well-formed result not marked last");

    // the second result of a byte follows its first without a gap
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !is_last) |=> (!empty && is_last))
        else $error("second result of a byte missing");

endmodule

bind utf8_stream_decoder utf8d_checker u_utf8d_checker (.*);

`default_nettype wire
